### design/sqdm_pkg.sv
// Shared types, codes and helper functions for the SDAP QFI-to-DRB mapper.
// Used by the front, back, top level and checker. No dependencies.

package sqdm_pkg;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CMD_MAP_WRITE = 2'd0,
      CMD_DOWNLINK  = 2'd1,
      CMD_UPLINK    = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_CTRL_PDU     = 2'd1,
      STATUS_NO_BEARER    = 2'd2,
      STATUS_FLOW_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_DRB_ACTIVE_MASK = 2'd0,
      REG_DEFAULT_DRB     = 2'd1,
      REG_DL_HEADER_MASK  = 2'd2,
      REG_UL_HEADER_MASK  = 2'd3
   } reg_index_type;

   // classified item as queued between front and back
   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  qfi;
      logic [5:0]  drb;
      logic        rqi;
      logic [7:0]  ulh;
      logic        qfi_ok;   // qfi below flow count
      logic        drb_le;   // drb within bearer count
      logic        hq_ok;    // uplink header qfi below flow count
   } job_type;

   typedef struct packed {
      logic [31:0] active_mask;
      logic [5:0]  default_drb;
      logic [31:0] dl_mask;
      logic [31:0] ul_mask;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  drb_out;
      logic        header_present;
      logic [7:0]  header_byte;
      logic        strip_header;
      logic [5:0]  qfi_out;
      logic        learned;
   } rsp_type;

   function automatic logic bit_of(input logic [31:0] mask, input logic [5:0] b);
      logic [5:0] bm1;
      bm1 = b - 6'd1;
      return mask[bm1[4:0]];
   endfunction

   function automatic logic bearer_ok(input logic [31:0] mask, input logic [5:0] b,
                                      input logic [5:0] num);
      return (b != 6'd0) && (b <= num) && bit_of(mask, b);
   endfunction

endpackage

### design/sqdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sqdm_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sqdm_front.sv
// Front end: accepts request transfers, classifies them and queues them
// in a two-entry queue for the back end. Depends on sqdm_pkg.

module sqdm_front #(
   parameter int NUM_BEARERS = 32,
   parameter int NUM_FLOWS   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [5:0]        req_qfi,
   input  logic [5:0]        req_drb_in,
   input  logic              req_rqi,
   input  logic [7:0]        req_ul_header,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sqdm_pkg::job_type pop_job
);

   sqdm_pkg::job_type slot_ff [2];
   sqdm_pkg::job_type job_in;
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   always_comb begin
      job_in.cmd    = sqdm_pkg::cmd_type'(req_cmd);
      job_in.qfi    = req_qfi;
      job_in.drb    = req_drb_in;
      job_in.rqi    = req_rqi;
      job_in.ulh    = req_ul_header;
      job_in.qfi_ok = {1'b0, req_qfi} < 7'(NUM_FLOWS);
      job_in.drb_le = {1'b0, req_drb_in} <= 7'(NUM_BEARERS);
      job_in.hq_ok  = {1'b0, req_ul_header[5:0]} < 7'(NUM_FLOWS);
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && (job_in.cmd != sqdm_pkg::CMD_UNUSED);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      priority if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

### design/sqdm_back.sv
// Back end: looks up the flow table, applies map writes and learning,
// and holds the result in the output register. Depends on sqdm_pkg, sqdm_ram.

module sqdm_back #(
   parameter int NUM_BEARERS = 32,
   parameter int NUM_FLOWS   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  sqdm_pkg::job_type pop_job,
   input  sqdm_pkg::cfg_type cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sqdm_pkg::rsp_type rsp
);

   localparam int         AW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
   localparam logic [5:0] NB = 6'(NUM_BEARERS);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type         state_ff;
   sqdm_pkg::job_type job_ff;
   sqdm_pkg::job_type cur_job;
   sqdm_pkg::rsp_type rsp_ff;
   sqdm_pkg::rsp_type res_in;
   logic              rsp_valid_ff;
   logic [NUM_FLOWS-1:0] vld_ff;
   logic              vld_rd_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [5:0]        rd_data;
   logic [5:0]        entry;
   logic [5:0]        wr_data;
   logic [5:0]        dl_b;
   logic              wr_req;
   logic              finish;
   logic              out_free;

   function automatic logic [AW-1:0] lookup_addr(input sqdm_pkg::job_type j);
      if (j.cmd == sqdm_pkg::CMD_UPLINK) begin
         return j.hq_ok ? j.ulh[AW-1:0] : '0;
      end
      return j.qfi_ok ? j.qfi[AW-1:0] : '0;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign finish    = (state_ff == ST_LOOKUP) && out_free;
   assign cur_job   = (state_ff == ST_IDLE) ? pop_job : job_ff;
   assign rd_addr   = lookup_addr(cur_job);
   assign wr_addr   = job_ff.qfi[AW-1:0];

   sqdm_ram #(
      .WIDTH (6),
      .DEPTH (NUM_FLOWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_req && finish),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      entry          = vld_rd_ff ? rd_data : 6'd0;
      res_in         = '0;
      res_in.status  = sqdm_pkg::STATUS_OK;
      res_in.qfi_out = job_ff.qfi;
      wr_req         = 1'b0;
      wr_data        = job_ff.drb;
      dl_b           = entry;
      unique case (job_ff.cmd)
         sqdm_pkg::CMD_MAP_WRITE: begin
            if (job_ff.qfi_ok && job_ff.drb_le) begin
               wr_req         = 1'b1;
               res_in.drb_out = job_ff.drb;
            end else begin
               res_in.status = sqdm_pkg::STATUS_NO_BEARER;
            end
         end
         sqdm_pkg::CMD_DOWNLINK: begin
            if (!job_ff.qfi_ok) begin
               res_in.status = sqdm_pkg::STATUS_NO_BEARER;
            end else begin
               if (!sqdm_pkg::bearer_ok(cfg.active_mask, entry, NB)) begin
                  if (sqdm_pkg::bearer_ok(cfg.active_mask, cfg.default_drb, NB)) begin
                     dl_b           = cfg.default_drb;
                     res_in.learned = 1'b1;
                     wr_req         = 1'b1;
                     wr_data        = cfg.default_drb;
                  end else begin
                     dl_b = 6'd0;
                  end
               end
               if (dl_b == 6'd0) begin
                  res_in.status = sqdm_pkg::STATUS_NO_BEARER;
               end else begin
                  res_in.drb_out = dl_b;
                  if (sqdm_pkg::bit_of(cfg.dl_mask, dl_b)) begin
                     res_in.header_present = 1'b1;
                     res_in.header_byte    = {res_in.learned, job_ff.rqi, job_ff.qfi};
                  end
               end
            end
         end
         sqdm_pkg::CMD_UPLINK: begin
            if (!sqdm_pkg::bearer_ok(cfg.active_mask, job_ff.drb, NB)) begin
               res_in.status = sqdm_pkg::STATUS_NO_BEARER;
            end else begin
               res_in.drb_out = job_ff.drb;
               if (sqdm_pkg::bit_of(cfg.ul_mask, job_ff.drb)) begin
                  res_in.qfi_out = job_ff.ulh[5:0];
                  priority if (!job_ff.ulh[7]) begin
                     res_in.status = sqdm_pkg::STATUS_CTRL_PDU;
                  end else if (job_ff.hq_ok && (entry == job_ff.drb)) begin
                     res_in.strip_header = 1'b1;
                  end else begin
                     res_in.status = sqdm_pkg::STATUS_FLOW_UNKNOWN;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
      end else begin
         vld_rd_ff <= vld_ff[rd_addr];
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (pop_valid) begin
                  job_ff   <= pop_job;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (finish) begin
                  rsp_ff       <= res_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (wr_req) begin
                     vld_ff[wr_addr] <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### design/sdap_qfi_drb_mapper.sv
// SDAP QFI-to-DRB mapper top level: register file, front end and back end.
// Depends on sqdm_pkg, sqdm_front, sqdm_back.
//
// Usage:
//  - Request channel (req_*): one transfer per item; cmd selects map write,
//    downlink or uplink. Items with the unused command are taken and dropped.
//  - Response channel (rsp_*): exactly one transfer per map write, downlink
//    or uplink item, in request order.
//  - Registers (APB): bearer active mask, default bearer, downlink and
//    uplink header masks at byte offsets 0x0, 0x4, 0x8, 0xC. Write them only
//    while no item is in flight.
//  - An item passes from the queue into the back end with the flow table's
//    registered read, then its response and table update are registered; the
//    back end takes no new item until that is done.
//  - A two-entry queue sits between front and back; requests are accepted
//    while it has room, even while a response waits in the output register.
//  - When the receiver stalls, the response holds; the back end then waits
//    and the queue fills, after which req_ready drops.
//  - Reset clears the register file and control state and marks every flow
//    unmapped at once through per-entry valid flags; no clearing pass is needed.

module sdap_qfi_drb_mapper #(
   parameter int NUM_BEARERS = 32,
   parameter int NUM_FLOWS   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [5:0]                    req_qfi,
   input  logic [5:0]                    req_drb_in,
   input  logic                          req_rqi,
   input  logic [7:0]                    req_ul_header,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [5:0]                    rsp_drb_out,
   output logic                          rsp_header_present,
   output logic [7:0]                    rsp_header_byte,
   output logic                          rsp_strip_header,
   output logic [5:0]                    rsp_qfi_out,
   output logic                          rsp_learned,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sqdm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   sqdm_pkg::cfg_type       cfg_ff;
   sqdm_pkg::job_type       pop_job;
   sqdm_pkg::rsp_type       rsp;
   sqdm_pkg::reg_index_type reg_index;
   logic                    pop_valid;
   logic                    pop_ready;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign reg_index = sqdm_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_index)
            sqdm_pkg::REG_DRB_ACTIVE_MASK: cfg_ff.active_mask <= pwdata;
            sqdm_pkg::REG_DEFAULT_DRB:     cfg_ff.default_drb <= pwdata[5:0];
            sqdm_pkg::REG_DL_HEADER_MASK:  cfg_ff.dl_mask     <= pwdata;
            sqdm_pkg::REG_UL_HEADER_MASK:  cfg_ff.ul_mask     <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sqdm_pkg::REG_DRB_ACTIVE_MASK: prdata = cfg_ff.active_mask;
         sqdm_pkg::REG_DEFAULT_DRB:     prdata = {26'd0, cfg_ff.default_drb};
         sqdm_pkg::REG_DL_HEADER_MASK:  prdata = cfg_ff.dl_mask;
         sqdm_pkg::REG_UL_HEADER_MASK:  prdata = cfg_ff.ul_mask;
         default:                       prdata = '0;
      endcase
   end

   sqdm_front #(
      .NUM_BEARERS (NUM_BEARERS),
      .NUM_FLOWS   (NUM_FLOWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_qfi       (req_qfi),
      .req_drb_in    (req_drb_in),
      .req_rqi       (req_rqi),
      .req_ul_header (req_ul_header),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_job       (pop_job)
   );

   sqdm_back #(
      .NUM_BEARERS (NUM_BEARERS),
      .NUM_FLOWS   (NUM_FLOWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_drb_out        = rsp.drb_out;
   assign rsp_header_present = rsp.header_present;
   assign rsp_header_byte    = rsp.header_byte;
   assign rsp_strip_header   = rsp.strip_header;
   assign rsp_qfi_out        = rsp.qfi_out;
   assign rsp_learned        = rsp.learned;

endmodule

### design/sqdm_checker.sv
// Port-level checker for the SDAP QFI-to-DRB mapper, bound to the top level.
// Depends on sqdm_pkg.

module sqdm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_drb_out,
   input logic       rsp_header_present,
   input logic [7:0] rsp_header_byte,
   input logic       rsp_strip_header,
   input logic [5:0] rsp_qfi_out,
   input logic       rsp_learned
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_drb_out) && $stable(rsp_header_byte) && $stable(rsp_qfi_out))
      else $error("response changed before transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_bearer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sqdm_pkg::STATUS_NO_BEARER) |->
      (rsp_drb_out == 6'd0) && !rsp_header_present && !rsp_strip_header && !rsp_learned)
      else $error("no-bearer response carries a bearer or flags");

   a_header_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_present |->
      (rsp_header_byte[7] == rsp_learned) && (rsp_header_byte[5:0] == rsp_qfi_out))
      else $error("downlink header byte inconsistent with response");

   a_flag_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_strip_header || rsp_learned) |->
      (rsp_status == sqdm_pkg::STATUS_OK) && (rsp_drb_out != 6'd0))
      else $error("strip or learned flag with error status");

endmodule

bind sdap_qfi_drb_mapper sqdm_checker u_sqdm_checker (.*);
